[rtl/tpw_pkg.sv]
// tpw_pkg: shared types and constants for the three-point weight tracker
// no dependencies; imported by every module of the block

package tpw_pkg;

  // widths of the fixed fields
  localparam int unsigned POWER_W = 32;
  localparam int unsigned DUTY_W  = 15;
  localparam int unsigned BITS_W  = 4;
  localparam int unsigned TASK_W  = 2;

  // reset value of the duty resolution register
  localparam logic [BITS_W-1:0] BITS_RESET = 4'd10;
  // smallest resolution that takes effect
  localparam logic [BITS_W-1:0] BITS_MIN   = 4'd2;

  // next task codes
  typedef enum logic [TASK_W-1:0] {
    TASK_SEND  = 2'd0,
    TASK_TRACK = 2'd1,
    TASK_MEAS  = 2'd2
  } task_code_t;

  // one result item
  typedef struct packed {
    logic              duty_write;
    logic [DUTY_W-1:0] duty_value;
    task_code_t        next_task;
    logic              track_done;
  } tpw_result_t;

endpackage

[rtl/tpw_core.sv]
// tpw_core: tracker sequencer, duty/power point registers and the step logic
// depends on tpw_pkg; produces one result per accepted request

module tpw_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tpw_pkg::BITS_W-1:0]   cfg_wr_data,
  input  logic                         req_accept,
  input  logic                         permission,
  input  logic [tpw_pkg::POWER_W-1:0]  measured_power,
  output tpw_pkg::tpw_result_t         result
);
  import tpw_pkg::*;

  typedef enum logic [1:0] {
    ST_SETUP    = 2'd0,
    ST_SET_DUTY = 2'd1,
    ST_CHECK    = 2'd2,
    ST_SELECT   = 2'd3
  } stage_t;

  stage_t              stage_r, stage_nxt;
  logic [BITS_W-1:0]   bits_r;
  logic [DUTY_W-1:0]   duty_r   [3];
  logic [DUTY_W-1:0]   duty_nxt [3];
  logic [POWER_W-1:0]  power_r  [3];
  logic [POWER_W-1:0]  power_nxt[3];
  logic [1:0]          cnt_r, cnt_nxt;

  logic [BITS_W-1:0]   bits_eff;
  logic [DUTY_W-1:0]   half;
  logic [DUTY_W-1:0]   dmax;
  logic [1:0]          idx;
  logic                up, down;
  logic signed [DUTY_W+1:0] ctr, ctr_lo, ctr_hi;

  // clamp a signed duty into [1, dmax]
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [DUTY_W+1:0] d,
                                                   input logic [DUTY_W-1:0] lim);
    logic signed [DUTY_W+1:0] lim_s;
    lim_s = signed'({2'b00, lim});
    if (d >= lim_s) begin
      clamp_duty = lim;
    end else if (d <= 17'sd1) begin
      clamp_duty = DUTY_W'(1);
    end else begin
      clamp_duty = d[DUTY_W-1:0];
    end
  endfunction

  // effective resolution, half scale and maximum duty
  assign bits_eff = (bits_r < BITS_MIN) ? BITS_MIN : bits_r;
  assign half     = DUTY_W'(16'd1 << (bits_eff - BITS_W'(1)));
  assign dmax     = DUTY_W'((16'd1 << bits_eff) - 16'd1);
  assign idx      = (cnt_r == 2'd3) ? 2'd2 : cnt_r;

  // weight signs and the moved centre
  assign up     = (power_r[2] >= power_r[1]) && (power_r[0] < power_r[1]);
  assign down   = (power_r[2] <  power_r[1]) && !(power_r[0] < power_r[1]);
  assign ctr    = signed'({2'b00, duty_r[1]}) + (up ? 17'sd1 : 17'sd0)
                  - (down ? 17'sd1 : 17'sd0);
  assign ctr_lo = ctr - 17'sd1;
  assign ctr_hi = ctr + 17'sd1;

  // step logic
  always_comb begin
    stage_nxt = stage_r;
    cnt_nxt   = cnt_r;
    for (int i = 0; i < 3; i++) begin
      duty_nxt[i]  = duty_r[i];
      power_nxt[i] = power_r[i];
    end
    result.duty_write = 1'b0;
    result.duty_value = '0;
    result.next_task  = TASK_SEND;
    result.track_done = 1'b0;

    unique case (stage_r)
      ST_SETUP: begin
        if (!permission) begin
          result.track_done = 1'b1;
        end else begin
          duty_nxt[1] = half;
          duty_nxt[0] = half - DUTY_W'(1);
          duty_nxt[2] = half + DUTY_W'(1);
          for (int i = 0; i < 3; i++) begin
            power_nxt[i] = '0;
          end
          cnt_nxt          = 2'd0;
          stage_nxt        = ST_SET_DUTY;
          result.next_task = TASK_TRACK;
        end
      end
      ST_SET_DUTY: begin
        result.duty_write = 1'b1;
        result.duty_value = duty_r[idx];
        result.next_task  = TASK_MEAS;
        stage_nxt         = ST_CHECK;
      end
      ST_CHECK: begin
        power_nxt[idx] = measured_power;
        if (idx == 2'd2) begin
          cnt_nxt   = 2'd0;
          stage_nxt = ST_SELECT;
        end else begin
          cnt_nxt   = idx + 2'd1;
          stage_nxt = ST_SET_DUTY;
        end
        result.next_task = TASK_TRACK;
      end
      ST_SELECT: begin
        duty_nxt[0] = clamp_duty(ctr_lo, dmax);
        duty_nxt[1] = clamp_duty(ctr, dmax);
        duty_nxt[2] = clamp_duty(ctr_hi, dmax);
        result.duty_write = 1'b1;
        result.duty_value = duty_nxt[idx];
        result.next_task  = TASK_SEND;
        stage_nxt         = ST_CHECK;
      end
      default: begin
        stage_nxt = ST_SETUP;
      end
    endcase
  end

  // sequencer state and point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_SETUP;
      bits_r  <= BITS_RESET;
      cnt_r   <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        duty_r[i]  <= '0;
        power_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        bits_r <= cfg_wr_data;
      end
      if (req_accept) begin
        stage_r <= stage_nxt;
        cnt_r   <= cnt_nxt;
        for (int i = 0; i < 3; i++) begin
          duty_r[i]  <= duty_nxt[i];
          power_r[i] <= power_nxt[i];
        end
      end
    end
  end

endmodule

[rtl/tpw_out_buf.sv]
// tpw_out_buf: two-entry result buffer (output register plus skid register)
// depends on tpw_pkg; stall toward the producer comes from a register

module tpw_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tpw_pkg::tpw_result_t  push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tpw_pkg::tpw_result_t  out_data
);
  import tpw_pkg::*;

  logic        out_v_r, skid_v_r;
  tpw_result_t out_r, skid_r;

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

[rtl/three_point_weight_mppt.sv]
// three-point weight comparison mppt: one tracker step per request
// each result is registered in the output buffer, via the skid register if the output is stalled
// throughput: one request per cycle while in_stall is low; all step logic sits in one register stage
// a two-entry result buffer takes one further request while a result is stalled
// reset (synchronous, rst_n low): setup stage, points and counter zero, resolution 10
module three_point_weight_mppt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tpw_pkg::BITS_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_permission,
  input  logic [tpw_pkg::POWER_W-1:0]  in_measured_power,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_duty_write,
  output logic [tpw_pkg::DUTY_W-1:0]   out_duty_value,
  output logic [tpw_pkg::TASK_W-1:0]   out_next_task,
  output logic                         out_track_done
);
  import tpw_pkg::*;

  logic        req_accept;
  logic        buf_full;
  tpw_result_t step_res, out_res;

  assign in_stall   = buf_full;
  assign req_accept = in_valid && !buf_full;

  // tracker step
  tpw_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .req_accept     (req_accept),
    .permission     (in_permission),
    .measured_power (in_measured_power),
    .result         (step_res)
  );

  // result buffering
  tpw_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_accept),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_duty_write = out_res.duty_write;
  assign out_duty_value = out_res.duty_value;
  assign out_next_task  = out_res.next_task;
  assign out_track_done = out_res.track_done;

endmodule

[rtl/tpw_checker.sv]
// tpw_checker: port-level assertions for the three-point weight tracker
// depends on tpw_pkg; bound to three_point_weight_mppt below

module tpw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_duty_write,
  input logic [tpw_pkg::DUTY_W-1:0]   out_duty_value,
  input logic [tpw_pkg::TASK_W-1:0]   out_next_task,
  input logic                         out_track_done
);
  import tpw_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_write)
      && $stable(out_duty_value) && $stable(out_next_task) && $stable(out_track_done))
    else $error("stalled result changed");

  // no duty write means a zero duty value
  a_idle_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_duty_write |-> out_duty_value == '0)
    else $error("duty value without duty write");

  // a written duty is never zero and comes from set duty or duty select
  a_duty_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_duty_write |-> out_duty_value != '0
      && (out_next_task == TASK_MEAS || out_next_task == TASK_SEND))
    else $error("bad duty write");

  // done only from setup without permission
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_track_done |-> !out_duty_write && out_next_task == TASK_SEND)
    else $error("done with wrong companion fields");

endmodule

bind three_point_weight_mppt tpw_checker u_tpw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_duty_write (out_duty_write),
  .out_duty_value (out_duty_value),
  .out_next_task  (out_next_task),
  .out_track_done (out_track_done)
);

[dv/three_point_weight_mppt_tb.sv]
// three_point_weight_mppt_tb: self-checking bench for the three-point weight mppt tracker
// predicts every tracker step in-bench and scoreboards the results; uses tpw_pkg and the rtl top
`timescale 1ns / 1ps

module three_point_weight_mppt_tb;
  import tpw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam logic [POWER_W-1:0] POWER_MAX = '1;

  // tracker sequencer stages, in the block's own encoding
  typedef enum logic [1:0] {
    STG_SETUP    = 2'd0,
    STG_SET_DUTY = 2'd1,
    STG_CHECK    = 2'd2,
    STG_SELECT   = 2'd3
  } tracker_stage_t;

  // shapes of power traces fed to the tracker
  typedef enum logic [1:0] {
    SEG_RAMP_UP   = 2'd0,
    SEG_RAMP_DOWN = 2'd1,
    SEG_FLAT      = 2'd2,
    SEG_NOISE     = 2'd3
  } seg_kind_t;

  typedef struct {
    logic               permission;
    logic [POWER_W-1:0] power;
  } track_req_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [BITS_W-1:0]  cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_permission = 1'b0;
  logic [POWER_W-1:0] in_measured_power = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_duty_write;
  logic [DUTY_W-1:0]  out_duty_value;
  logic [TASK_W-1:0]  out_next_task;
  logic               out_track_done;

  // requests waiting to be driven and step results waiting to arrive
  track_req_t  track_reqs_q[$];
  tpw_result_t step_results_q[$];

  // in-bench copy of the tracker state and its resolution register
  logic [BITS_W-1:0]  res_bits = BITS_RESET;
  tracker_stage_t     stg = STG_SETUP;
  logic [15:0]        duty_pt [3] = '{default: '0};
  logic [POWER_W-1:0] pwr_pt [3] = '{default: '0};
  logic [1:0]         pt_cnt = '0;

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned moves_up = 0;
  int unsigned moves_down = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  bit          quiet = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  three_point_weight_mppt uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_permission     (in_permission),
    .in_measured_power (in_measured_power),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_duty_write    (out_duty_write),
    .out_duty_value    (out_duty_value),
    .out_next_task     (out_next_task),
    .out_track_done    (out_track_done)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int clamp_duty(int d, int dmax);
    if (d >= dmax) return dmax;
    if (d <= 1) return 1;
    return d;
  endfunction

  // one tracker step: updates the bench copy of the state, returns the result
  function automatic tpw_result_t track_step(logic perm, logic [POWER_W-1:0] pwr);
    tpw_result_t r;
    int unsigned nb;
    int unsigned idx;
    int unsigned half;
    int          dmax;
    int          c;
    int          wab;
    int          wac;
    nb   = (res_bits < BITS_MIN) ? BITS_MIN : res_bits;
    dmax = (1 << nb) - 1;
    idx  = (pt_cnt > 2'd2) ? 2 : pt_cnt;
    r = '0;
    r.next_task = TASK_SEND;
    case (stg)
      STG_SETUP: begin
        if (!perm) begin
          r.track_done = 1'b1;
        end else begin
          // neighbours of half scale are not clamped here
          half = 1 << (nb - 1);
          duty_pt[1] = 16'(half);
          duty_pt[0] = 16'(half - 1);
          duty_pt[2] = 16'(half + 1);
          pwr_pt = '{default: '0};
          pt_cnt = '0;
          stg = STG_SET_DUTY;
          r.next_task = TASK_TRACK;
        end
      end
      STG_SET_DUTY: begin
        r.duty_write = 1'b1;
        r.duty_value = duty_pt[idx][DUTY_W-1:0];
        stg = STG_CHECK;
        r.next_task = TASK_MEAS;
      end
      STG_CHECK: begin
        // power width matches the input, so no saturation can occur
        pwr_pt[idx] = pwr;
        if (idx >= 2) begin
          pt_cnt = '0;
          stg = STG_SELECT;
        end else begin
          pt_cnt = 2'(idx + 1);
          stg = STG_SET_DUTY;
        end
        r.next_task = TASK_TRACK;
      end
      default: begin
        wab = (pwr_pt[2] >= pwr_pt[1]) ? 1 : -1;
        wac = (pwr_pt[0] < pwr_pt[1]) ? 1 : -1;
        c = int'(duty_pt[1]);
        if (wab + wac == 2) begin
          c = c + 1;
          moves_up++;
        end else if (wab + wac == -2) begin
          c = c - 1;
          moves_down++;
        end
        // centre + 1 is formed wide, so the top clamps rather than wraps
        duty_pt[0] = 16'(clamp_duty(c - 1, dmax));
        duty_pt[1] = 16'(clamp_duty(c, dmax));
        duty_pt[2] = 16'(clamp_duty(c + 1, dmax));
        r.duty_write = 1'b1;
        r.duty_value = duty_pt[idx][DUTY_W-1:0];
        stg = STG_CHECK;
        r.next_task = TASK_SEND;
      end
    endcase
    return r;
  endfunction

  task automatic push_req(logic perm, logic [POWER_W-1:0] pwr);
    track_req_t q;
    q.permission = perm;
    q.power = pwr;
    track_reqs_q.push_back(q);
  endtask

  // power traces: rising traces push the centre up, falling ones down, flat holds it
  task automatic add_segments(int unsigned n_items);
    int unsigned left;
    int unsigned len;
    seg_kind_t   k;
    logic [POWER_W-1:0] p;
    left = n_items;
    while (left > 0) begin
      k = seg_kind_t'($urandom_range(0, 3));
      len = $urandom_range(6, 48);
      if (len > left) len = left;
      case (k)
        SEG_RAMP_UP:   p = $urandom_range(0, 32'h7FFF_FFFF);
        SEG_RAMP_DOWN: p = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
        SEG_FLAT: begin
          case ($urandom_range(0, 2))
            0:       p = '0;
            1:       p = POWER_MAX;
            default: p = $urandom;
          endcase
        end
        default: p = $urandom;
      endcase
      repeat (len) begin
        push_req(1'($urandom_range(0, 1)), p);
        case (k)
          SEG_RAMP_UP:   p = p + $urandom_range(1, 1 << 20);
          SEG_RAMP_DOWN: p = p - $urandom_range(1, 1 << 20);
          SEG_NOISE:     p = $urandom;
          default:       p = p;
        endcase
      end
      left = left - len;
    end
  endtask

  task automatic write_resolution(logic [BITS_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    res_bits = v;
  endtask

  task automatic wait_drained();
    while (track_reqs_q.size() != 0 || in_valid || step_results_q.size() != 0)
      @(posedge clk);
  endtask

  // request driver: predicts each accepted request, then offers the next one
  always @(posedge clk) begin : drv
    track_req_t  q;
    tpw_result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r = track_step(in_permission, in_measured_power);
        step_results_q.push_back(r);
      end
      if (in_valid && in_stall) begin
        // stalled request holds its payload
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (track_reqs_q.size() != 0 && !quiet && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (track_reqs_q.size() != 0) begin
        q = track_reqs_q.pop_front();
        in_valid          <= 1'b1;
        in_permission     <= q.permission;
        in_measured_power <= q.power;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: checks accepted results, then picks the next stall value
  always @(posedge clk) begin : mon
    tpw_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (step_results_q.size() == 0) begin
          $error("result arrived with no tracker step pending");
          errors++;
        end else begin
          e = step_results_q.pop_front();
          checked++;
          if (out_duty_write !== e.duty_write) begin
            $error("duty_write: expected %0d, got %0d", e.duty_write, out_duty_write);
            errors++;
          end
          if (out_duty_value !== e.duty_value) begin
            $error("duty_value: expected %0d, got %0d", e.duty_value, out_duty_value);
            errors++;
          end
          if (out_next_task !== TASK_W'(e.next_task)) begin
            $error("next_task: expected %0d, got %0d", e.next_task, out_next_task);
            errors++;
          end
          if (out_track_done !== e.track_done) begin
            $error("track_done: expected %0d, got %0d", e.track_done,
                   out_track_done);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("three_point_weight_mppt test failed");
      $finish;
    end
  end

  initial begin : stim
    logic [BITS_W-1:0] plan [N_PHASES];
    int unsigned       idle_plan [4];
    plan = '{4'd0, 4'd1, 4'd2, 4'd15, 4'd3, 4'd14, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd2};
    idle_plan = '{25, 0, 40, 15};
    for (int i = 8; i < 11; i++) plan[i] = BITS_W'($urandom_range(0, 15));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // setup without permission, then permission at the reset resolution
    idle_pct = 20;
    push_req(1'b0, '0);
    push_req(1'b0, POWER_MAX);
    push_req(1'b0, $urandom);
    push_req(1'b1, '0);
    // first round: lower point worst, upper ties centre, so the centre moves up
    push_req(1'b1, $urandom);
    push_req(1'b1, '0);
    push_req(1'b1, $urandom);
    push_req(1'b1, POWER_MAX);
    push_req(1'b1, $urandom);
    push_req(1'b1, POWER_MAX);
    push_req(1'b0, $urandom);
    // second round: upper worse, lower better, so the centre moves down
    push_req(1'b1, POWER_MAX);
    push_req(1'b0, $urandom);
    push_req(1'b1, 32'd5);
    push_req(1'b0, $urandom);
    push_req(1'b1, '0);
    push_req(1'b1, $urandom);
    // third round: all equal, centre stays
    push_req(1'b0, 32'd7);
    push_req(1'b1, $urandom);
    push_req(1'b1, 32'd7);
    push_req(1'b0, $urandom);
    push_req(1'b1, 32'd7);
    push_req(1'b1, $urandom);
    wait_drained();

    // random phases over several resolutions; stored duties reclamp at the next select
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_resolution(plan[ph]);
      idle_pct = idle_plan[ph % 4];
      quiet = (ph == N_PHASES - 1);
      add_segments(PHASE_ITEMS);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (step_results_q.size() != 0) begin
      $error("%0d tracker steps never produced a result", step_results_q.size());
      errors++;
    end
    $display("checked %0d tracker steps across %0d resolution settings",
             checked, N_PHASES + 1);
    $display("centre moved up %0d times and down %0d times", moves_up, moves_down);
    if (errors == 0) begin
      $display("three_point_weight_mppt test passed");
    end else begin
      $display("three_point_weight_mppt test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tpw_pkg.sv
rtl/tpw_core.sv
rtl/tpw_out_buf.sv
rtl/three_point_weight_mppt.sv
rtl/tpw_checker.sv
dv/three_point_weight_mppt_tb.sv
